// File: sv/diameter_length_deframer_defines.svh
// Assertion macros for the Diameter length deframer.
`ifndef DIAMETER_LENGTH_DEFRAMER_DEFINES_SVH
`define DIAMETER_LENGTH_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DLD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DLD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer sequence check failed");

`endif

// File: sv/dld_pkg.sv
// Types and constants shared by the Diameter length deframer files.
`timescale 1ns / 1ps
package dld_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0] HDR_BYTES      = 24'd4;
    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 24'd20;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 24'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

    typedef struct packed {
        logic [LEN_W-1:0] min_length;
        logic [LEN_W-1:0] max_length;
    } dld_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  byte_offset;
        logic              frame_start;
        logic              frame_last;
        logic              length_error;
    } dld_result_t;

endpackage

// File: sv/dld_if.sv
// Stream channel interfaces: byte input and framed byte output.
`timescale 1ns / 1ps
interface dld_in_if;
    logic                       valid;
    logic                       ready;
    logic [dld_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dld_out_if;
    logic                       valid;
    logic                       ready;
    logic [dld_pkg::BYTE_W-1:0] out_byte;
    logic [dld_pkg::LEN_W-1:0]  byte_offset;
    logic                       frame_start;
    logic                       frame_last;
    logic                       length_error;

    modport source (output valid, output out_byte, output byte_offset, output frame_start,
                    output frame_last, output length_error, input ready);
    modport sink   (input valid, input out_byte, input byte_offset, input frame_start,
                    input frame_last, input length_error, output ready);
endinterface

// File: sv/dld_cfg.sv
// Length limit registers behind the plain write port.
`timescale 1ns / 1ps
module dld_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dld_pkg::LEN_W-1:0]     cfg_wdata,
    output dld_pkg::dld_cfg_t             cfg
);

    dld_pkg::dld_cfg_t cfg_reg;
    dld_pkg::dld_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dld_pkg::REG_MIN_LENGTH: cfg_next.min_length = cfg_wdata;
                dld_pkg::REG_MAX_LENGTH: cfg_next.max_length = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length <= dld_pkg::MIN_LENGTH_RST;
            cfg_reg.max_length <= dld_pkg::MAX_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/dld_parser.sv
// Header collection, length check and per-byte framing state.
`timescale 1ns / 1ps
module dld_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [dld_pkg::BYTE_W-1:0] data_byte,
    input  dld_pkg::dld_cfg_t          cfg,
    output dld_pkg::dld_result_t       result
);

    localparam int LW = dld_pkg::LEN_W;

    logic          in_body_reg, in_body_next;
    logic [LW-1:0] byte_count_reg, byte_count_next;
    logic [LW-1:0] length_accum_reg, length_accum_next;
    logic [LW-1:0] frame_length_reg, frame_length_next;

    logic [LW-1:0] count_inc;
    logic [LW-1:0] accum_shift;
    logic          start, last, err;

    always_comb
    begin
        count_inc         = byte_count_reg + 1'b1;
        accum_shift       = {length_accum_reg[LW-dld_pkg::BYTE_W-1:0], data_byte};
        in_body_next      = in_body_reg;
        byte_count_next   = byte_count_reg;
        length_accum_next = length_accum_reg;
        frame_length_next = frame_length_reg;
        start             = 1'b0;
        last              = 1'b0;
        err               = 1'b0;

        if (!in_body_reg)
        begin
            start             = (byte_count_reg == '0);
            length_accum_next = accum_shift;
            byte_count_next   = count_inc;
            if (count_inc >= dld_pkg::HDR_BYTES)
            begin
                if (accum_shift < cfg.min_length || accum_shift > cfg.max_length)
                begin
                    err               = 1'b1;
                    byte_count_next   = '0;
                    length_accum_next = '0;
                end
                else if (accum_shift <= dld_pkg::HDR_BYTES)
                begin
                    // whole message fits in the header
                    frame_length_next = accum_shift;
                    last              = 1'b1;
                    byte_count_next   = '0;
                    length_accum_next = '0;
                end
                else
                begin
                    frame_length_next = accum_shift;
                    in_body_next      = 1'b1;
                    byte_count_next   = dld_pkg::HDR_BYTES;
                end
            end
        end
        else
        begin
            byte_count_next = count_inc;
            if (count_inc >= frame_length_reg)
            begin
                last              = 1'b1;
                in_body_next      = 1'b0;
                byte_count_next   = '0;
                length_accum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg      <= 1'b0;
            byte_count_reg   <= '0;
            length_accum_reg <= '0;
            frame_length_reg <= '0;
        end
        else if (step)
        begin
            in_body_reg      <= in_body_next;
            byte_count_reg   <= byte_count_next;
            length_accum_reg <= length_accum_next;
            frame_length_reg <= frame_length_next;
        end
    end

    assign result.out_byte     = data_byte;
    assign result.byte_offset  = byte_count_reg;
    assign result.frame_start  = start;
    assign result.frame_last   = last;
    assign result.length_error = err;

endmodule

// File: sv/diameter_length_deframer.sv
// Top level of the Diameter length deframer.
// Usage:
//   stream: one byte per beat from the TCP byte stream (valid/ready).
//   frames: one beat per input byte, carrying the byte, its offset in the
//           message, a start flag on header byte 0, a last flag on the byte
//           that completes an accepted message, and length_error on the
//           fourth header byte when the length falls outside the limits.
//   cfg_*:  write port for min_length (index 0) and max_length (index 1);
//           write only while no beats are in flight.
// Path: an accepted byte is held in the input register, then moves to the
//   result register and appears on frames; two register stages (input register, result register).
// Throughput: one byte per cycle, sustained while frames.ready is high; the
//   parser next state is computed combinationally between the two registers.
// Reset: asynchronous, active low; empties both stages, clears the framing
//   state (next byte is header byte 0) and loads the limits 20 and 65536.
// Stall: when frames.ready is low with a beat on frames the result register holds; the input
//   register still takes one more byte, then stream.ready drops until the
//   result beat is taken.
`timescale 1ns / 1ps
`include "diameter_length_deframer_defines.svh"
module diameter_length_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    dld_in_if.sink                        stream,
    dld_out_if.source                     frames,
    input  logic                          cfg_we,
    input  logic [dld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dld_pkg::LEN_W-1:0]     cfg_wdata
);

    dld_pkg::dld_cfg_t    cfg;
    dld_pkg::dld_result_t result;
    dld_pkg::dld_result_t result_reg;

    logic                       in_valid_reg, in_valid_next;
    logic [dld_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       advance;
    logic                       step;
    logic                       take;

    dld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dld_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .cfg       (cfg),
        .result    (result)
    );

    always_comb
    begin
        advance        = !out_valid_reg || frames.ready;
        step           = in_valid_reg && advance;
        take           = stream.valid && stream.ready;
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    assign stream.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= stream.data_byte;
        end
        if (step)
        begin
            result_reg <= result;
        end
    end

    assign frames.valid        = out_valid_reg;
    assign frames.out_byte     = result_reg.out_byte;
    assign frames.byte_offset  = result_reg.byte_offset;
    assign frames.frame_start  = result_reg.frame_start;
    assign frames.frame_last   = result_reg.frame_last;
    assign frames.length_error = result_reg.length_error;

    `DLD_ASSERT_NOW(a_start_at_zero, frames.valid && frames.frame_start, frames.byte_offset == '0)
    `DLD_ASSERT_NOW(a_err_on_fourth, frames.valid && frames.length_error, frames.byte_offset == 24'd3)
    `DLD_ASSERT_NOW(a_err_not_last, frames.valid && frames.length_error, !frames.frame_last)
    `DLD_ASSERT_NEXT(a_full_stalls, in_valid_reg && out_valid_reg && !frames.ready, in_valid_reg)

endmodule
